/* hdl/ffsa_pkg.sv */
// Shared types and constants for the first-fit segment allocator.
// Used by every module in the block; depends on nothing.
package ffsa_pkg;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] CFG_BASE_ADDRESS = 2'd0;
  localparam logic [1:0] CFG_BUFFER_BYTES = 2'd1;

  localparam logic [15:0] BUFFER_BYTES_RESET = 16'd4096;

  localparam logic [2:0] STATUS_OK             = 3'd0;
  localparam logic [2:0] STATUS_ZERO_SIZE      = 3'd1;
  localparam logic [2:0] STATUS_NO_FIT         = 3'd2;
  localparam logic [2:0] STATUS_NOT_ALLOCATED  = 3'd3;

  typedef struct packed {
    logic        op;
    logic [15:0] request_bytes;
    logic [31:0] release_address;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] granted_address;
    logic [7:0]  allocated_count;
    logic [7:0]  free_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] offset;
    logic [15:0] length;
  } seg_entry_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SPLIT,
    ST_TAKE,
    ST_WNEXT,
    ST_WPREV,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_ALLOC,
    PH_HIT,
    PH_NEXT,
    PH_PREV
  } phase_t;

endpackage

/* hdl/first_fit_segment_allocator_top.sv */
// First-fit segment allocator: top level with the result output register.
// Instantiates ffsa_ctrl and ffsa_mem; uses ffsa_pkg.
// Requests are handled one at a time: in_ready is high only in the idle state, and a new
// request is taken only after the last result has passed to the output register; each
// scan reads the descriptors through the single descriptor memory read port.
// Reset: one free segment of 4096 bytes at offset 0; the ST_INIT state after reset writes it.
module first_fit_segment_allocator_top
  import ffsa_pkg::*;
#(
  parameter int DESCRIPTORS = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        out_data
);

  localparam int AW = $clog2(DESCRIPTORS);

  logic          res_valid;
  logic          res_ready;
  rsp_t          res_data;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  seg_entry_t    mem_wdata;
  logic [AW-1:0] mem_raddr;
  seg_entry_t    mem_rdata;

  ffsa_ctrl #(
    .DESCRIPTORS(DESCRIPTORS),
    .AW(AW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res_data(res_data),
    .mem_we(mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .mem_raddr(mem_raddr),
    .mem_rdata(mem_rdata)
  );

  ffsa_mem #(
    .DEPTH(DESCRIPTORS),
    .AW(AW)
  ) u_mem (
    .clk(clk),
    .we(mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data <= res_data;
    end
  end

endmodule

/* hdl/ffsa_mem.sv */
// Descriptor memory holding offset and length of each segment.
// One write port and one registered read port; uses ffsa_pkg.
module ffsa_mem
  import ffsa_pkg::*;
#(
  parameter int DEPTH = 128,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  seg_entry_t    wdata,
  input  logic [AW-1:0] raddr,
  output seg_entry_t    rdata
);

  seg_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ffsa_ctrl.sv */
// Sequencer, flag vectors and the shared scan compare of the allocator.
// Drives the descriptor memory; uses ffsa_pkg.
module ffsa_ctrl
  import ffsa_pkg::*;
#(
  parameter int DESCRIPTORS = 128,
  parameter int AW          = $clog2(DESCRIPTORS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          in_valid,
  output logic          in_ready,
  input  req_t          in_data,
  output logic          res_valid,
  input  logic          res_ready,
  output rsp_t          res_data,
  output logic          mem_we,
  output logic [AW-1:0] mem_waddr,
  output seg_entry_t    mem_wdata,
  output logic [AW-1:0] mem_raddr,
  input  seg_entry_t    mem_rdata
);

  localparam logic [AW:0] CNT_END = (AW + 1)'(DESCRIPTORS);

  state_t                 state, state_next;
  phase_t                 phase;
  logic [AW:0]            cnt;
  logic [31:0]            base_address;
  logic [15:0]            buffer_bytes;
  logic [DESCRIPTORS-1:0] seg_valid;
  logic [DESCRIPTORS-1:0] seg_taken;
  logic [7:0]             taken_total;
  logic [7:0]             open_total;
  req_t                   req;
  logic                   found;
  logic [AW-1:0]          found_idx;
  logic [15:0]            found_off;
  logic [15:0]            found_len;
  logic                   spare_found;
  logic [AW-1:0]          spare_idx;
  logic [AW-1:0]          hit_idx;
  logic [15:0]            hit_off;
  logic [15:0]            hit_len;
  logic [2:0]             status;
  logic [31:0]            grant;

  logic [AW-1:0]          e_idx;
  logic                   eval;
  logic                   ev;
  logic                   et;
  logic [16:0]            seg_end;
  logic [16:0]            hit_end;
  logic                   match;
  logic                   spare_match;
  logic                   cfg_bytes;

  assign cfg_bytes = cfg_we && (cfg_index == CFG_BUFFER_BYTES);

  assign e_idx   = AW'(cnt - 1'b1);
  assign eval    = (state == ST_SCAN) && (cnt != '0);
  assign ev      = seg_valid[e_idx];
  assign et      = seg_taken[e_idx];
  assign seg_end = {1'b0, mem_rdata.offset} + {1'b0, mem_rdata.length};
  assign hit_end = {1'b0, hit_off} + {1'b0, hit_len};

  always_comb begin
    match = 1'b0;
    case (phase)
      PH_ALLOC: begin
        match = ev && !et && (mem_rdata.length >= req.request_bytes) &&
                (!found || (mem_rdata.offset < found_off));
      end
      PH_HIT: begin
        match = !found && ev && et &&
                ((base_address + {16'b0, mem_rdata.offset}) == req.release_address);
      end
      PH_NEXT: begin
        match = !found && (e_idx != hit_idx) && ev && !et &&
                ({1'b0, mem_rdata.offset} == hit_end);
      end
      PH_PREV: begin
        match = !found && (e_idx != hit_idx) && ev && !et &&
                (seg_end == {1'b0, hit_off});
      end
      default: match = 1'b0;
    endcase
    match       = match && eval;
    spare_match = eval && (phase == PH_ALLOC) && !ev && !spare_found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    res_valid  = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    case (state)
      ST_INIT: begin
        mem_we     = 1'b1;
        mem_wdata  = '{offset: 16'd0, length: buffer_bytes};
        state_next = ST_IDLE;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.op == OP_FREE) begin
            state_next = ST_SCAN;
          end else if (in_data.request_bytes == 16'd0) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (cnt == CNT_END) begin
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        case (phase)
          PH_ALLOC: begin
            if (!found) begin
              state_next = ST_DONE;
            end else if ((found_len > req.request_bytes) && spare_found) begin
              state_next = ST_SPLIT;
            end else begin
              state_next = ST_TAKE;
            end
          end
          PH_HIT:  state_next = found ? ST_SCAN : ST_DONE;
          PH_NEXT: state_next = found ? ST_WNEXT : ST_SCAN;
          PH_PREV: state_next = found ? ST_WPREV : ST_DONE;
          default: state_next = ST_DONE;
        endcase
      end
      ST_SPLIT: begin
        mem_we     = 1'b1;
        mem_waddr  = spare_idx;
        mem_wdata  = '{offset: found_off + req.request_bytes,
                       length: found_len - req.request_bytes};
        state_next = ST_TAKE;
      end
      ST_TAKE: begin
        mem_we     = 1'b1;
        mem_waddr  = found_idx;
        mem_wdata  = '{offset: found_off, length: req.request_bytes};
        state_next = ST_DONE;
      end
      ST_WNEXT: begin
        mem_we     = 1'b1;
        mem_waddr  = hit_idx;
        mem_wdata  = '{offset: hit_off, length: hit_len};
        state_next = ST_SCAN;
      end
      ST_WPREV: begin
        mem_we     = 1'b1;
        mem_waddr  = found_idx;
        mem_wdata  = '{offset: found_off, length: found_len + hit_len};
        state_next = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
    if (cfg_bytes) begin
      mem_we    = 1'b1;
      mem_waddr = '0;
      mem_wdata = '{offset: 16'd0, length: cfg_data[15:0]};
    end
  end

  assign mem_raddr = cnt[AW-1:0];

  assign res_data = '{status: status, granted_address: grant,
                      allocated_count: taken_total, free_count: open_total};

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= 32'd0;
      buffer_bytes <= BUFFER_BYTES_RESET;
      seg_valid    <= DESCRIPTORS'(1);
      seg_taken    <= '0;
      taken_total  <= 8'd0;
      open_total   <= 8'd1;
      cnt          <= '0;
      phase        <= PH_ALLOC;
      found        <= 1'b0;
      spare_found  <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            req         <= in_data;
            grant       <= 32'd0;
            cnt         <= '0;
            found       <= 1'b0;
            spare_found <= 1'b0;
            phase       <= (in_data.op == OP_FREE) ? PH_HIT : PH_ALLOC;
            status      <= ((in_data.op == OP_ALLOC) && (in_data.request_bytes == 16'd0)) ?
                           STATUS_ZERO_SIZE : STATUS_OK;
          end
        end
        ST_SCAN: begin
          cnt <= cnt + 1'b1;
          if (match) begin
            found     <= 1'b1;
            found_idx <= e_idx;
            found_off <= mem_rdata.offset;
            found_len <= mem_rdata.length;
          end
          if (spare_match) begin
            spare_found <= 1'b1;
            spare_idx   <= e_idx;
          end
        end
        ST_DECIDE: begin
          case (phase)
            PH_ALLOC: begin
              if (!found) begin
                status <= STATUS_NO_FIT;
              end
            end
            PH_HIT: begin
              if (!found) begin
                status <= STATUS_NOT_ALLOCATED;
              end else begin
                hit_idx              <= found_idx;
                hit_off              <= found_off;
                hit_len              <= found_len;
                seg_taken[found_idx] <= 1'b0;
                taken_total          <= taken_total - 8'd1;
                open_total           <= open_total + 8'd1;
                phase                <= PH_NEXT;
                cnt                  <= '0;
                found                <= 1'b0;
              end
            end
            PH_NEXT: begin
              if (found) begin
                hit_len              <= hit_len + found_len;
                seg_valid[found_idx] <= 1'b0;
                open_total           <= open_total - 8'd1;
              end else begin
                phase <= PH_PREV;
                cnt   <= '0;
                found <= 1'b0;
              end
            end
            PH_PREV: begin
              if (found) begin
                seg_valid[hit_idx] <= 1'b0;
                open_total         <= open_total - 8'd1;
              end
            end
            default: status <= STATUS_OK;
          endcase
        end
        ST_SPLIT: begin
          seg_valid[spare_idx] <= 1'b1;
          seg_taken[spare_idx] <= 1'b0;
          open_total           <= open_total + 8'd1;
        end
        ST_TAKE: begin
          seg_taken[found_idx] <= 1'b1;
          open_total           <= open_total - 8'd1;
          taken_total          <= taken_total + 8'd1;
          grant                <= base_address + {16'b0, found_off};
        end
        ST_WNEXT: begin
          phase <= PH_PREV;
          cnt   <= '0;
          found <= 1'b0;
        end
        default: cnt <= cnt;
      endcase
      if (cfg_we && (cfg_index == CFG_BASE_ADDRESS)) begin
        base_address <= cfg_data;
      end
      if (cfg_bytes) begin
        buffer_bytes <= cfg_data[15:0];
        seg_valid    <= (cfg_data[15:0] != 16'd0) ? DESCRIPTORS'(1) : '0;
        seg_taken    <= '0;
        taken_total  <= 8'd0;
        open_total   <= (cfg_data[15:0] != 16'd0) ? 8'd1 : 8'd0;
      end
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("accepted beat did not start work");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt <= CNT_END))
    else $error("scan counter ran past the table");

  a_fit_large_enough: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DECIDE) && (phase == PH_ALLOC) && found) |->
      (found_len >= req.request_bytes))
    else $error("chosen segment is smaller than the request");

  a_take_counts: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAKE) |=> (taken_total == $past(taken_total) + 8'd1))
    else $error("allocated count not advanced on grant");

endmodule
